/* hdl/bit_vector_rank_ctz_engine_defines.svh */
// Assertion macros for the bit-vector rank / trailing-zero engine.
`ifndef BIT_VECTOR_RANK_CTZ_ENGINE_DEFINES_SVH
`define BIT_VECTOR_RANK_CTZ_ENGINE_DEFINES_SVH

// Check a condition in the same cycle.
`define BVRC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvrc check failed");

// Check a condition in the cycle after the antecedent.
`define BVRC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvrc check failed");

`endif

/* hdl/bvrc_pkg.sv */
`timescale 1ns / 1ps

package bvrc_pkg;

    localparam int unsigned CAPACITY_BITS_DEF = 1024;
    localparam int IDX_W   = 11;
    localparam int CNT_W   = 11;
    localparam int LEN_W   = 12;
    localparam int BYTES_W = 8;
    localparam int WORD_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int POP_W   = 6;

    typedef enum logic [2:0] {
        REQ_GET    = 3'd0,
        REQ_PUT    = 3'd1,
        REQ_RANK   = 3'd2,
        REQ_TZ     = 3'd3,
        REQ_DROP   = 3'd4,
        REQ_SETLEN = 3'd5
    } req_op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [IDX_W-1:0]   index;
        logic               value;
        logic [BYTES_W-1:0] byte_count;
    } req_t;

    typedef struct packed {
        logic             bit_value;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] length_bits;
        logic             error;
    } rsp_t;

    typedef struct packed {
        req_op_t            op;
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  prev;
        logic [SHIFT_W-1:0] bit_sel;
        logic               put_val;
        logic [SHIFT_W-1:0] shift;
        logic               keep_none;
        logic               keep_all;
        logic [SHIFT_W-1:0] keep_bits;
    } wu_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]  wdata;
        logic [POP_W-1:0]   pop;
        logic               nonzero;
        logic [SHIFT_W-1:0] low_bit;
        logic               bit_out;
    } wu_out_t;

    function automatic logic [POP_W-1:0] popcount32(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        v = w - ((w >> 1) & 32'h5555_5555);
        v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
        v = (v + (v >> 4)) & 32'h0F0F_0F0F;
        v = v * 32'h0101_0101;
        return v[29:24];
    endfunction

    function automatic logic [SHIFT_W-1:0] lowest_set32(input logic [WORD_W-1:0] w);
        logic [SHIFT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i])
            begin
                r = SHIFT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/bvrc_word_unit.sv */
`timescale 1ns / 1ps

module bvrc_word_unit
    import bvrc_pkg::*;
(
    input  wu_in_t  wu_in,
    output wu_out_t wu_out
);

    logic [WORD_W-1:0]   keep_mask;
    logic [WORD_W-1:0]   masked;
    logic [WORD_W-1:0]   put_word;
    logic [2*WORD_W-1:0] pair_shifted;

    always_comb
    begin
        if (wu_in.keep_none)
        begin
            keep_mask = '0;
        end
        else if (wu_in.keep_all)
        begin
            keep_mask = '1;
        end
        else
        begin
            keep_mask = (32'h1 << wu_in.keep_bits) - 32'h1;
        end
        masked = wu_in.word & keep_mask;

        put_word = wu_in.word;
        put_word[wu_in.bit_sel] = wu_in.put_val;

        pair_shifted = {wu_in.word, wu_in.prev} >> wu_in.shift;

        unique case (wu_in.op)
            REQ_PUT:    wu_out.wdata = put_word;
            REQ_DROP:   wu_out.wdata = pair_shifted[WORD_W-1:0];
            REQ_SETLEN: wu_out.wdata = masked;
            default:    wu_out.wdata = wu_in.word;
        endcase

        wu_out.pop     = popcount32(masked);
        wu_out.nonzero = |wu_in.word;
        wu_out.low_bit = lowest_set32(wu_in.word);
        wu_out.bit_out = wu_in.word[wu_in.bit_sel];
    end

endmodule

/* hdl/bit_vector_rank_ctz_engine.sv */
// Channel | Signals                        | Moves
// req     | req_valid, req_ready, req      | one request per transfer
// rsp     | rsp_valid, rsp_ready, rsp      | one result per request
// Words of 32 bits sit in a memory read one word a cycle; a request reads N words:
// get inside the length and put one, rank ceil(index/32), trailing zeros
// ceil(length/32), set length ceil(length/32) when shrinking, drop bytes
// ceil(length/32) + 1, a refused request none.
// After reset the memory is swept to zero, one word a cycle.
// One request at a time; the result holds until taken, and req_ready is low meanwhile.
`timescale 1ns / 1ps
`include "bit_vector_rank_ctz_engine_defines.svh"

module bit_vector_rank_ctz_engine
    import bvrc_pkg::*;
#(
    parameter int unsigned CAPACITY_BITS = CAPACITY_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int unsigned NWORDS = (CAPACITY_BITS + 31) / 32;
    localparam int AW = $clog2(NWORDS);
    localparam int SW = AW + 2;
    localparam logic [AW-1:0] LAST_INIT = AW'(NWORDS - 1);
    localparam logic [SW-1:0] WORDS_SW  = SW'(NWORDS);

    state_t state_reg, state_next;

    logic [AW-1:0]      init_reg, init_next;
    logic [SW-1:0]      scan_reg, scan_next;
    logic [SW-1:0]      end_reg, end_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    req_op_t            op_reg, op_next;
    logic [SHIFT_W-1:0] sel_reg, sel_next;
    logic               val_reg, val_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [SW-1:0]      ws_reg, ws_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               bit_reg, bit_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               err_reg, err_next;
    logic               found_reg, found_next;
    logic [WORD_W-1:0]  prev_reg, prev_next;

    logic               rd_vld_reg;
    logic               rd_zero_reg;
    logic [SW-1:0]      rd_addr_reg;
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  mem [NWORDS];

    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  word_eff;
    logic [SW-1:0]      drop_addr;

    logic [LEN_W-1:0]   idx12;
    logic [LEN_W-1:0]   r8_idx;
    logic [LEN_W-1:0]   r8_next;
    logic [LEN_W-1:0]   drop_len;
    logic [LEN_W-1:0]   rk_sum;
    logic [LEN_W:0]     lw_sum;
    logic [SW-1:0]      len_words;
    logic [SW-1:0]      rank_words;
    logic [SW-1:0]      idx_word;
    logic [SW-1:0]      dec_ws;
    logic               idx_ge_cap;
    logic               r8_gt_cap;
    logic               dec_err;
    logic [LEN_W-1:0]   dec_len;
    logic [LEN_W-1:0]   dec_pos;
    logic [SW-1:0]      dec_start;
    logic [SW-1:0]      dec_end;

    logic [31:0]        base32;
    logic [31:0]        pos32;
    logic [31:0]        diff32;
    wu_in_t             wu_in;
    wu_out_t            wu_out;

    // request decode
    always_comb
    begin
        idx12      = LEN_W'(req.index);
        r8_idx     = (idx12 + LEN_W'(7)) & ~LEN_W'(7);
        r8_next    = (idx12 + LEN_W'(8)) & ~LEN_W'(7);
        drop_len   = LEN_W'({req.byte_count, 3'b000});
        rk_sum     = idx12 + LEN_W'(31);
        lw_sum     = (LEN_W + 1)'(len_reg) + (LEN_W + 1)'(31);
        len_words  = SW'(lw_sum[LEN_W:5]);
        rank_words = SW'(rk_sum[LEN_W-1:5]);
        idx_word   = SW'(req.index[IDX_W-1:5]);
        dec_ws     = SW'(req.byte_count[BYTES_W-1:2]);
        idx_ge_cap = 32'(req.index) >= CAPACITY_BITS;
        r8_gt_cap  = 32'(r8_idx) > CAPACITY_BITS;

        dec_err   = 1'b0;
        dec_len   = len_reg;
        dec_pos   = idx12;
        dec_start = '0;
        dec_end   = '0;
        unique case (req.req_type)
            REQ_GET:
            begin
                dec_err = idx_ge_cap;
                if (!idx_ge_cap && idx12 < len_reg)
                begin
                    dec_start = idx_word;
                    dec_end   = idx_word + SW'(1);
                end
            end
            REQ_PUT:
            begin
                if (idx_ge_cap)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    if (idx12 >= len_reg)
                    begin
                        dec_len = r8_next;
                    end
                    dec_start = idx_word;
                    dec_end   = idx_word + SW'(1);
                end
            end
            REQ_RANK:
            begin
                if (r8_gt_cap)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    if (idx12 > len_reg)
                    begin
                        dec_len = r8_idx;
                    end
                    dec_end = rank_words;
                end
            end
            REQ_TZ:
            begin
                dec_end = len_words;
            end
            REQ_DROP:
            begin
                if (drop_len > len_reg)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    dec_len   = len_reg - drop_len;
                    dec_start = dec_ws;
                    dec_end   = dec_ws + len_words + SW'(1);
                end
            end
            REQ_SETLEN:
            begin
                if (r8_gt_cap)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    if (r8_idx < len_reg)
                    begin
                        dec_end = len_words;
                    end
                    dec_pos = r8_idx;
                    dec_len = r8_idx;
                end
            end
            default:
            begin
                dec_err = 1'b1;
            end
        endcase
    end

    // word unit hookup
    always_comb
    begin
        word_eff = rd_zero_reg ? '0 : rdata_reg;
        base32   = 32'({rd_addr_reg, 5'b00000});
        pos32    = 32'(pos_reg);
        diff32   = pos32 - base32;

        wu_in.op        = op_reg;
        wu_in.word      = word_eff;
        wu_in.prev      = prev_reg;
        wu_in.bit_sel   = sel_reg;
        wu_in.put_val   = val_reg;
        wu_in.shift     = shift_reg;
        wu_in.keep_none = base32 >= pos32;
        wu_in.keep_all  = diff32 >= 32'd32;
        wu_in.keep_bits = diff32[SHIFT_W-1:0];
    end

    bvrc_word_unit u_word_unit (
        .wu_in  (wu_in),
        .wu_out (wu_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_reg == LAST_INIT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg >= end_reg && !rd_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready       = state_reg == ST_IDLE;
        rsp_valid       = state_reg == ST_DONE;
        mem_re          = state_reg == ST_SCAN && scan_reg < end_reg;
        mem_raddr       = scan_reg[AW-1:0];
        rsp.bit_value   = bit_reg;
        rsp.count       = cnt_reg;
        rsp.length_bits = len_reg[CNT_W-1:0];
        rsp.error       = err_reg;
    end

    // datapath
    always_comb
    begin
        init_next  = init_reg;
        scan_next  = scan_reg;
        end_next   = end_reg;
        len_next   = len_reg;
        op_next    = op_reg;
        sel_next   = sel_reg;
        val_next   = val_reg;
        shift_next = shift_reg;
        ws_next    = ws_reg;
        pos_next   = pos_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        found_next = found_reg;
        prev_next  = prev_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        drop_addr  = rd_addr_reg - ws_reg - SW'(1);

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_reg;
                init_next = init_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_op_t'(req.req_type);
                    sel_next   = req.index[SHIFT_W-1:0];
                    val_next   = req.value;
                    shift_next = {req.byte_count[1:0], 3'b000};
                    ws_next    = dec_ws;
                    pos_next   = dec_pos;
                    len_next   = dec_len;
                    err_next   = dec_err;
                    scan_next  = dec_start;
                    end_next   = dec_end;
                    bit_next   = 1'b0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg < end_reg)
                begin
                    scan_next = scan_reg + SW'(1);
                end
                if (rd_vld_reg)
                begin
                    unique case (op_reg)
                        REQ_GET:
                        begin
                            bit_next = wu_out.bit_out;
                        end
                        REQ_PUT, REQ_SETLEN:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rd_addr_reg[AW-1:0];
                            mem_wdata = wu_out.wdata;
                        end
                        REQ_RANK:
                        begin
                            cnt_next = cnt_reg + CNT_W'(wu_out.pop);
                        end
                        REQ_TZ:
                        begin
                            if (!found_reg && wu_out.nonzero)
                            begin
                                found_next = 1'b1;
                                cnt_next   = CNT_W'({rd_addr_reg, 5'b00000})
                                           + CNT_W'(wu_out.low_bit);
                            end
                        end
                        REQ_DROP:
                        begin
                            prev_next = word_eff;
                            if (rd_addr_reg > ws_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = drop_addr[AW-1:0];
                                mem_wdata = wu_out.wdata;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (scan_reg >= end_reg && op_reg == REQ_TZ && !found_reg)
                begin
                    cnt_next = CNT_W'(len_reg);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            init_reg   <= '0;
            scan_reg   <= '0;
            end_reg    <= '0;
            len_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            scan_reg   <= scan_next;
            end_reg    <= end_next;
            len_reg    <= len_next;
            rd_vld_reg <= mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sel_reg     <= sel_next;
        val_reg     <= val_next;
        shift_reg   <= shift_next;
        ws_reg      <= ws_next;
        pos_reg     <= pos_next;
        bit_reg     <= bit_next;
        cnt_reg     <= cnt_next;
        err_reg     <= err_next;
        found_reg   <= found_next;
        prev_reg    <= prev_next;
        rd_addr_reg <= scan_reg;
        rd_zero_reg <= scan_reg >= WORDS_SW;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    `BVRC_ASSERT_NOW(a_len_fmt, 1'b1, len_reg[2:0] == 3'b000 && 32'(len_reg) <= CAPACITY_BITS)
    `BVRC_ASSERT_NOW(a_no_stray_write, state_reg == ST_IDLE || state_reg == ST_DONE, !mem_we)
    `BVRC_ASSERT_NEXT(a_read_in_scan, mem_re, state_reg == ST_SCAN || state_reg == ST_DONE)

endmodule

/* tb/tb_bit_vector_rank_ctz_engine.sv */
`timescale 1ns / 1ps

module tb_bit_vector_rank_ctz_engine;
    import bvrc_pkg::*;

    localparam int unsigned CAP = CAPACITY_BITS_DEF;
    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;
    localparam int RANDOM_REQUESTS = 800;

    typedef struct {
        req_t r;
        bit   drain;
    } backlog_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_pkt = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_pkt;

    backlog_item_t request_backlog[$];
    rsp_t pending_results[$];
    logic [CAP-1:0] shadow_bits = '0;
    int unsigned shadow_len = 0;
    int unsigned accepted_count = 0;
    int unsigned fail_count = 0;

    bit_vector_rank_ctz_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_pkt),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_pkt)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned round_up8(input int unsigned n);
        return (n + 7) & ~32'd7;
    endfunction

    function automatic bit take_break();
        bit calm;
        calm = (accepted_count >= 300) && (accepted_count < 450);
        return !calm && ($urandom_range(99) < 27);
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int unsigned idx;
        int unsigned n;
        int i;
        res = '0;
        idx = r.index;
        case (r.req_type)
            REQ_GET:
            begin
                if (idx >= CAP)
                    res.error = 1'b1;
                else if (idx < shadow_len)
                    res.bit_value = shadow_bits[idx];
            end
            REQ_PUT:
            begin
                if (idx >= CAP)
                    res.error = 1'b1;
                else
                begin
                    if (idx >= shadow_len)
                        shadow_len = round_up8(idx + 1);
                    shadow_bits[idx] = r.value;
                end
            end
            REQ_RANK:
            begin
                n = round_up8(idx);
                if (n > CAP)
                    res.error = 1'b1;
                else
                begin
                    if (idx > shadow_len)
                        shadow_len = n;
                    for (i = 0; i < int'(idx); i++)
                        res.count += shadow_bits[i];
                end
            end
            REQ_TZ:
            begin
                res.count = CNT_W'(shadow_len);
                for (i = CAP - 1; i >= 0; i--)
                    if (shadow_bits[i])
                        res.count = CNT_W'(i);
            end
            REQ_DROP:
            begin
                n = r.byte_count;
                n = n * 8;
                if (n > shadow_len)
                    res.error = 1'b1;
                else
                begin
                    shadow_bits = shadow_bits >> n;
                    shadow_len -= n;
                end
            end
            REQ_SETLEN:
            begin
                n = round_up8(idx);
                if (n > CAP)
                    res.error = 1'b1;
                else
                begin
                    for (i = n; i < CAP; i++)
                        shadow_bits[i] = 1'b0;
                    shadow_len = n;
                end
            end
            default:
                res.error = 1'b1;
        endcase
        res.length_bits = CNT_W'(shadow_len);
        return res;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int unsigned pick;
        int unsigned spot;
        r.value = 1'($urandom_range(1));
        r.byte_count = 8'($urandom_range(255));
        spot = $urandom_range(99);
        if (spot < 65)
            r.index = 11'($urandom_range(1023));
        else if (spot < 85)
            r.index = 11'($urandom_range(63));
        else if (spot < 94)
            r.index = 11'($urandom_range(1031, 1016));
        else
            r.index = 11'($urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < 33)
        begin
            r.req_type = REQ_PUT;
            r.value = ($urandom_range(99) < 55);
        end
        else if (pick < 48)
            r.req_type = REQ_GET;
        else if (pick < 62)
            r.req_type = REQ_RANK;
        else if (pick < 74)
            r.req_type = REQ_TZ;
        else if (pick < 85)
        begin
            r.req_type = REQ_DROP;
            spot = $urandom_range(99);
            if (spot < 70)
                r.byte_count = 8'($urandom_range(16));
            else if (spot < 90)
                r.byte_count = 8'($urandom_range(128));
        end
        else if (pick < 96)
        begin
            r.req_type = REQ_SETLEN;
            if ($urandom_range(99) < 40)
                r.index = 11'($urandom_range(64));
        end
        else
            r.req_type = ($urandom_range(1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
        return r;
    endfunction

    task automatic add_request(input logic [2:0] op, input int unsigned idx,
                               input bit val, input int unsigned bytes);
        backlog_item_t item;
        item.r.req_type = op;
        item.r.index = 11'(idx);
        item.r.value = val;
        item.r.byte_count = 8'(bytes);
        item.drain = 1'b0;
        request_backlog.push_back(item);
    endtask

    // hold the next request while a transfer is due, else advance the backlog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_pkt <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                pending_results.push_back(apply_request(req_pkt));
                accepted_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (request_backlog.size() != 0 && !take_break()
                    && !(request_backlog[0].drain && pending_results.size() != 0))
                begin
                    req_pkt <= request_backlog[0].r;
                    req_valid <= 1'b1;
                    void'(request_backlog.pop_front());
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !take_break();
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_pkt.bit_value !== want.bit_value)
                begin
                    $error("bit_value: expected %0d, got %0d", want.bit_value, rsp_pkt.bit_value);
                    fail_count++;
                end
                if (rsp_pkt.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp_pkt.count);
                    fail_count++;
                end
                if (rsp_pkt.length_bits !== want.length_bits)
                begin
                    $error("length_bits: expected %0d, got %0d",
                           want.length_bits, rsp_pkt.length_bits);
                    fail_count++;
                end
                if (rsp_pkt.error !== want.error)
                begin
                    $error("error: expected %0d, got %0d", want.error, rsp_pkt.error);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        backlog_item_t item;
        int k;
        add_request(REQ_TZ, 0, 1'b0, 0);
        add_request(REQ_GET, 0, 1'b1, 0);
        add_request(REQ_GET, 1024, 1'b0, 255);
        add_request(REQ_GET, 2047, 1'b1, 0);
        add_request(REQ_PUT, 1023, 1'b1, 0);
        add_request(REQ_PUT, 1024, 1'b1, 0);
        add_request(REQ_GET, 1023, 1'b0, 0);
        add_request(REQ_RANK, 1024, 1'b0, 0);
        add_request(REQ_RANK, 1025, 1'b0, 0);
        add_request(REQ_TZ, 0, 1'b0, 0);
        add_request(REQ_DROP, 0, 1'b0, 129);
        add_request(REQ_DROP, 0, 1'b0, 255);
        add_request(REQ_DROP, 2047, 1'b1, 1);
        add_request(REQ_TZ, 0, 1'b0, 0);
        add_request(REQ_SETLEN, 1000, 1'b0, 0);
        add_request(REQ_TZ, 0, 1'b0, 0);
        add_request(REQ_SETLEN, 1025, 1'b0, 0);
        add_request(REQ_SETLEN, 1017, 1'b0, 0);
        add_request(REQ_SETLEN, 0, 1'b0, 0);
        add_request(REQ_RANK, 13, 1'b0, 0);
        add_request(REQ_PUT, 5, 1'b1, 0);
        add_request(REQ_RANK, 6, 1'b0, 0);
        add_request(REQ_RANK, 5, 1'b0, 0);
        add_request(REQ_DROP, 0, 1'b0, 0);
        add_request(REQ_UNUSED_A, 0, 1'b0, 0);
        add_request(REQ_UNUSED_B, 2047, 1'b1, 255);
        for (k = 0; k < RANDOM_REQUESTS; k++)
        begin
            item.r = random_request();
            item.drain = (k % 200 == 0);
            request_backlog.push_back(item);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS bit_vector_rank_ctz_engine");
        else
            $display("FAIL bit_vector_rank_ctz_engine");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL bit_vector_rank_ctz_engine");
        $finish;
    end

endmodule
